/* hdl/mqurl_pkg.sv */
// Shared types and constants for the MQTT broker URL field splitter.
// No dependencies; imported by mqurl_parse and mqtt_url_field_splitter.
package mqurl_pkg;

    // Field tags carried with each byte
    localparam logic [2:0] FLD_NONE  = 3'd0;
    localparam logic [2:0] FLD_USER  = 3'd1;
    localparam logic [2:0] FLD_PASS  = 3'd2;
    localparam logic [2:0] FLD_HOST  = 3'd3;
    localparam logic [2:0] FLD_TOPIC = 3'd4;

    // Final status codes
    localparam logic [3:0] ST_OK          = 4'd0;
    localparam logic [3:0] ST_BAD_SCHEME  = 4'd1;
    localparam logic [3:0] ST_NO_COLON    = 4'd2;
    localparam logic [3:0] ST_USER_LONG   = 4'd3;
    localparam logic [3:0] ST_NO_AT       = 4'd4;
    localparam logic [3:0] ST_PASS_LONG   = 4'd5;
    localparam logic [3:0] ST_NO_SLASH    = 4'd6;
    localparam logic [3:0] ST_HOST_BLANK  = 4'd7;
    localparam logic [3:0] ST_HOST_LONG   = 4'd8;
    localparam logic [3:0] ST_TOPIC_BLANK = 4'd9;
    localparam logic [3:0] ST_TOPIC_LONG  = 4'd10;

    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_AT    = 8'h40;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_S     = 8'h73;
    localparam logic [7:0] CH_NUL   = 8'h00;

    typedef struct packed {
        logic [2:0] field;
        logic [7:0] char_out;
        logic       tls;
        logic       done_res;
        logic [3:0] status;
    } t_result;

    // Expected scheme byte at a prefix position: "mqtts://" or "mqtt://"
    function automatic logic [7:0] prefix_char(input logic tls, input logic [2:0] pos);
        logic [7:0] ch;
        case (pos)
            3'd0:    ch = 8'h6D;                  // m
            3'd1:    ch = 8'h71;                  // q
            3'd2:    ch = 8'h74;                  // t
            3'd3:    ch = 8'h74;                  // t
            3'd4:    ch = tls ? CH_S : CH_COLON;
            3'd5:    ch = tls ? CH_COLON : CH_SLASH;
            3'd6:    ch = CH_SLASH;
            3'd7:    ch = tls ? CH_SLASH : CH_NUL;
            default: ch = CH_NUL;
        endcase
        return ch;
    endfunction

endpackage

/* hdl/mqurl_parse.sv */
// URL parse state and per-byte tagging logic: one byte per enabled cycle.
// Depends on mqurl_pkg for result type, field tags and status codes.
module mqurl_parse #(
    parameter int USER_BUF_BYTES  = 64,
    parameter int PASS_BUF_BYTES  = 64,
    parameter int HOST_BUF_BYTES  = 64,
    parameter int TOPIC_BUF_BYTES = 128
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic [7:0]         i_char,
    input  logic               i_last,
    output mqurl_pkg::t_result o_res
);
    import mqurl_pkg::*;

    typedef enum logic [2:0] {
        PH_SCHEME = 3'd0,
        PH_USER   = 3'd1,
        PH_PASS   = 3'd2,
        PH_HOST   = 3'd3,
        PH_TOPIC  = 3'd4,
        PH_HALT   = 3'd5
    } t_phase;

    localparam logic [7:0] USER_LIM  = 8'(USER_BUF_BYTES);
    localparam logic [7:0] PASS_LIM  = 8'(PASS_BUF_BYTES);
    localparam logic [7:0] HOST_LIM  = 8'(HOST_BUF_BYTES);
    localparam logic [7:0] TOPIC_LIM = 8'(TOPIC_BUF_BYTES);

    t_phase     r_phase, n_phase;
    logic [2:0] r_pos, n_pos;
    logic [7:0] r_len, n_len;
    logic [3:0] r_err, n_err;
    logic       r_tls, n_tls;

    always_comb begin
        logic       is_end;
        logic [7:0] len_inc;
        logic [2:0] fld;
        logic [3:0] fin_err;
        logic       tls_now;

        is_end  = i_last || (i_char == CH_NUL);
        len_inc = (r_len == 8'hFF) ? r_len : r_len + 8'd1;
        fld     = FLD_NONE;
        n_phase = r_phase;
        n_pos   = r_pos;
        n_len   = r_len;
        n_err   = r_err;
        tls_now = r_tls;

        if (i_char != CH_NUL) begin
            case (r_phase)
                PH_SCHEME: begin
                    if (r_pos == 3'd4 && !r_tls && i_char == CH_S) tls_now = 1'b1;
                    if (i_char != prefix_char(tls_now, r_pos)) begin
                        if (r_err == ST_OK) n_err = ST_BAD_SCHEME;
                        n_phase = PH_HALT;
                    end else if ((tls_now && r_pos == 3'd7) || (!tls_now && r_pos == 3'd6)) begin
                        n_pos   = 3'd0;
                        n_phase = PH_USER;
                        n_len   = 8'd0;
                    end else begin
                        n_pos = r_pos + 3'd1;
                    end
                end
                PH_USER: begin
                    if (i_char == CH_COLON) begin
                        if (r_len >= USER_LIM) begin
                            if (r_err == ST_OK) n_err = ST_USER_LONG;
                            n_phase = PH_HALT;
                        end else begin
                            n_phase = PH_PASS;
                            n_len   = 8'd0;
                        end
                    end else begin
                        fld   = FLD_USER;
                        n_len = len_inc;
                    end
                end
                PH_PASS: begin
                    if (i_char == CH_AT) begin
                        if (r_len >= PASS_LIM) begin
                            if (r_err == ST_OK) n_err = ST_PASS_LONG;
                            n_phase = PH_HALT;
                        end else begin
                            n_phase = PH_HOST;
                            n_len   = 8'd0;
                        end
                    end else begin
                        fld   = FLD_PASS;
                        n_len = len_inc;
                    end
                end
                PH_HOST: begin
                    if (i_char == CH_SLASH) begin
                        if (r_len == 8'd0) begin
                            if (r_err == ST_OK) n_err = ST_HOST_BLANK;
                            n_phase = PH_HALT;
                        end else if (r_len >= HOST_LIM) begin
                            if (r_err == ST_OK) n_err = ST_HOST_LONG;
                            n_phase = PH_HALT;
                        end else begin
                            n_phase = PH_TOPIC;
                            n_len   = 8'd0;
                        end
                    end else begin
                        fld   = FLD_HOST;
                        n_len = len_inc;
                    end
                end
                PH_TOPIC: begin
                    fld   = FLD_TOPIC;
                    n_len = len_inc;
                end
                default: n_phase = PH_HALT;
            endcase
        end

        // an open field at end of string decides the status unless an error is held
        fin_err = n_err;
        if (n_err == ST_OK) begin
            case (n_phase)
                PH_SCHEME: fin_err = ST_BAD_SCHEME;
                PH_USER:   fin_err = ST_NO_COLON;
                PH_PASS:   fin_err = ST_NO_AT;
                PH_HOST:   fin_err = ST_NO_SLASH;
                PH_TOPIC: begin
                    if (n_len == 8'd0)          fin_err = ST_TOPIC_BLANK;
                    else if (n_len >= TOPIC_LIM) fin_err = ST_TOPIC_LONG;
                end
                default: fin_err = n_err;
            endcase
        end

        o_res.field    = fld;
        o_res.char_out = i_char;
        o_res.tls      = tls_now;
        o_res.done_res = is_end;
        o_res.status   = is_end ? fin_err : ST_OK;

        n_tls = tls_now;
        if (is_end) begin
            n_phase = PH_SCHEME;
            n_pos   = 3'd0;
            n_len   = 8'd0;
            n_err   = ST_OK;
            n_tls   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SCHEME;
            r_pos   <= 3'd0;
            r_len   <= 8'd0;
            r_err   <= ST_OK;
            r_tls   <= 1'b0;
        end else if (i_en) begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
            r_len   <= n_len;
            r_err   <= n_err;
            r_tls   <= n_tls;
        end
    end

    // a held error always parks the parser in the halt phase
    a_err_halts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_err != ST_OK |-> r_phase == PH_HALT)
        else $error("error held outside halt phase");

    // the final byte of a URL returns the parser to its start state
    a_end_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_en && o_res.done_res |=> r_phase == PH_SCHEME && r_err == ST_OK && !r_tls)
        else $error("state not cleared after final byte");

    // a held error is never replaced before the end of the URL
    a_err_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_en && r_err != ST_OK && !o_res.done_res |=> r_err == $past(r_err))
        else $error("held error changed");

    // content tags only appear once the scheme has been matched
    a_tag_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.field != FLD_NONE |-> r_phase != PH_SCHEME && r_phase != PH_HALT)
        else $error("byte tagged outside a content field");

endmodule

/* hdl/mqtt_url_field_splitter.sv */
// Path: an accepted byte is held in the input register, then its result is held in the result register.
// Throughput: one byte per cycle while m_axis_tready is high; the parse state update is one short compare/count step.
// Stalls on the master side back up through the input register to s_axis_tready.
// Reset (i_rst_n low, synchronous) empties both registers and returns to the scheme phase.
// Top level of the MQTT broker URL field splitter: stream ports, input and result registers.
// Depends on mqurl_pkg and mqurl_parse.
module mqtt_url_field_splitter #(
    parameter int USER_BUF_BYTES  = 64,
    parameter int PASS_BUF_BYTES  = 64,
    parameter int HOST_BUF_BYTES  = 64,
    parameter int TOPIC_BUF_BYTES = 128
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] char_in
    input  logic        s_axis_tlast,   // last
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [7:0] char_out, [8] tls, [12:9] status, [15:13] zero
    output logic [2:0]  m_axis_tuser,   // [2:0] field
    output logic        m_axis_tlast    // done_res
);
    import mqurl_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_char;
    logic       r_in_last;
    logic       r_out_valid;
    t_result    r_out;
    t_result    w_res;
    logic       w_adv;

    assign w_adv         = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_adv;

    mqurl_parse #(
        .USER_BUF_BYTES (USER_BUF_BYTES),
        .PASS_BUF_BYTES (PASS_BUF_BYTES),
        .HOST_BUF_BYTES (HOST_BUF_BYTES),
        .TOPIC_BUF_BYTES(TOPIC_BUF_BYTES)
    ) u_parse (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (w_adv),
        .i_char (r_in_char),
        .i_last (r_in_last),
        .o_res  (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_axis_tready) r_in_valid <= s_axis_tvalid;
            if (w_adv) r_out_valid <= 1'b1;
            else if (m_axis_tready) r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_char <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
        end
        if (w_adv) r_out <= w_res;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'b000, r_out.status, r_out.tls, r_out.char_out};
    assign m_axis_tuser  = r_out.field;
    assign m_axis_tlast  = r_out.done_res;

    // a pending request in the input register is never dropped while stalled
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !w_adv |=> r_in_valid && r_in_char == $past(r_in_char))
        else $error("pending input request lost");

    // a stalled result is not overwritten by the parser
    a_out_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !m_axis_tready |-> !w_adv)
        else $error("result register overrun");

    // status is only nonzero on the final result of a URL
    a_status_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out.done_res |-> r_out.status == ST_OK)
        else $error("status on non-final result");

endmodule
